[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/ses_pkg.sv]
// ----------------------------------------------------------------------------
// ses_pkg
// Types and fixed constants of the sorted event scheduler.
// ----------------------------------------------------------------------------
package ses_pkg;

  // Input operation codes
  localparam logic MODE_SCHED = 1'b0;
  localparam logic MODE_ADV   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FIRED    = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Due time of the reserved rebase entry
  localparam logic [31:0] REBASE_DELAY = 32'h7FFF_FFFF;

  // Fired results per advance transaction
  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned N_WIDTH = 5;

  // Sequencer states
  typedef enum logic [6:0] {
    S_INIT     = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_INS_SCAN = 7'b0000100,
    S_INS_PUT  = 7'b0001000,
    S_ADV_CHK  = 7'b0010000,
    S_POP      = 7'b0100000,
    S_SPARE    = 7'b1000000
  } state_e;

endpackage

[rtl/ses_ram.sv]
// ----------------------------------------------------------------------------
// ses_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ses_ram #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word each cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sorted_event_scheduler.sv]
// ----------------------------------------------------------------------------
// sorted_event_scheduler
// Timed event queue kept in due-time order in one RAM; schedules events and
// advances time, firing due events in order with periodic time rebasing.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  command   in         start & !busy                 mode, event_id, amount
//  result    out        result_valid (one cycle)      status, fired_id,
//                                                     fire_time, last
//
//  Schedule: a full queue is refused, else a sorted insert moves later
//  entries up. Advance: checks the head entry and shifts the remaining
//  entries down on each pop; a rebase adds a full shift sweep and a sorted
//  insert. All work goes through the single read and single write port of
//  the entry RAM. After reset the block writes the rebase entry (busy high).
//  Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_event_scheduler
  import ses_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [ID_WIDTH-1:0] event_id_i,
  input  logic [30:0]         amount_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [ID_WIDTH-1:0] fired_id_o,
  output logic [31:0]         fire_time_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = 33 + ID_WIDTH;

  state_e              state_q, state_d;
  logic [31:0]         cur_q, cur_d;
  logic [31:0]         tgt_q, tgt_d;
  logic [31:0]         sub_q, sub_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [N_WIDTH-1:0]  n_q, n_d;
  logic                reb_q, reb_d;
  logic [31:0]         ins_due_q, ins_due_d;
  logic [ID_WIDTH-1:0] ins_id_q, ins_id_d;
  logic                ins_mark_q, ins_mark_d;
  logic                ins_adv_q, ins_adv_d;
  logic [ID_WIDTH-1:0] pend_id_q, pend_id_d;
  logic [31:0]         pend_time_q, pend_time_d;
  logic                stb_q, stb_d;
  logic [1:0]          status_q, status_d;
  logic [ID_WIDTH-1:0] fid_q, fid_d;
  logic [31:0]         ftime_q, ftime_d;
  logic                last_q, last_d;
  logic                fwd_q, fwd_d;
  logic [EW-1:0]       fwd_data_q, fwd_data_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [EW-1:0]       wdata, rdata, ram_rdata;
  logic [31:0]         rd_due;
  logic [ID_WIDTH-1:0] rd_id;
  logic                rd_mark;

  ses_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Forward a word written in the same cycle as its read
  assign fwd_d      = we && (waddr == raddr);
  assign fwd_data_d = wdata;
  assign rdata      = fwd_q ? fwd_data_q : ram_rdata;

  assign rd_due  = rdata[31:0];
  assign rd_id   = rdata[32 +: ID_WIDTH];
  assign rd_mark = rdata[EW-1];

  // Sequence schedule, advance, pop and insert sweeps
  always_comb begin
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_p1;
    logic [CW:0]   cnt_p1;
    state_d     = state_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    sub_d       = sub_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    n_d         = n_q;
    reb_d       = reb_q;
    ins_due_d   = ins_due_q;
    ins_id_d    = ins_id_q;
    ins_mark_d  = ins_mark_q;
    ins_adv_d   = ins_adv_q;
    pend_id_d   = pend_id_q;
    pend_time_d = pend_time_q;
    stb_d       = 1'b0;
    status_d    = status_q;
    fid_d       = fid_q;
    ftime_d     = ftime_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    cnt_m1      = cnt_q - 1'b1;
    idx_p1      = CW'(idx_q) + 1'b1;
    cnt_p1      = {1'b0, cnt_q} + 1'b1;

    case (state_q)
      S_INIT: begin
        // Seed the rebase entry
        we      = 1'b1;
        waddr   = '0;
        wdata   = {1'b1, {ID_WIDTH{1'b0}}, REBASE_DELAY};
        state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          if (mode_i == MODE_SCHED) begin
            if (cnt_p1 >= (CW+1)'(QUEUE_DEPTH)) begin
              stb_d    = 1'b1;
              status_d = ST_FULL;
              fid_d    = '0;
              ftime_d  = '0;
              last_d   = 1'b1;
            end else begin
              ins_due_d  = cur_q + {1'b0, amount_i};
              ins_id_d   = event_id_i;
              ins_mark_d = 1'b0;
              ins_adv_d  = 1'b0;
              if (cnt_q == '0) begin
                idx_d   = '0;
                state_d = S_INS_PUT;
              end else begin
                raddr   = cnt_m1[AW-1:0];
                idx_d   = AW'(cnt_q);
                state_d = S_INS_SCAN;
              end
            end
          end else begin
            tgt_d   = cur_q + {1'b0, amount_i};
            n_d     = '0;
            raddr   = '0;
            state_d = S_ADV_CHK;
          end
        end
      end

      S_INS_SCAN: begin
        // Shift later entries up until the slot is found
        we    = 1'b1;
        waddr = idx_q;
        if (rd_due > ins_due_q) begin
          wdata = rdata;
          if (idx_q == AW'(1)) begin
            idx_d   = '0;
            state_d = S_INS_PUT;
          end else begin
            raddr = idx_q - 1'b1 - 1'b1;
            idx_d = idx_q - 1'b1;
          end
        end else begin
          wdata = {ins_mark_q, ins_id_q, ins_due_q};
          cnt_d = cnt_q + 1'b1;
          if (ins_adv_q) begin
            raddr   = '0;
            state_d = S_ADV_CHK;
          end else begin
            stb_d    = 1'b1;
            status_d = ST_ACCEPTED;
            fid_d    = '0;
            ftime_d  = '0;
            last_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end

      S_INS_PUT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = {ins_mark_q, ins_id_q, ins_due_q};
        cnt_d = cnt_q + 1'b1;
        if (ins_adv_q) begin
          raddr   = '0;
          state_d = S_ADV_CHK;
        end else begin
          stb_d    = 1'b1;
          status_d = ST_ACCEPTED;
          fid_d    = '0;
          ftime_d  = '0;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_ADV_CHK: begin
        // Inspect the head entry against the target
        if (cnt_q == '0 || rd_due > tgt_q || (!rd_mark && n_q == N_WIDTH'(MAX_OUT))) begin
          if (cnt_q == '0 || rd_due > tgt_q) begin
            cur_d = tgt_q;
          end
          stb_d   = 1'b1;
          last_d  = 1'b1;
          state_d = S_IDLE;
          if (n_q == '0) begin
            status_d = ST_NONE;
            fid_d    = '0;
            ftime_d  = '0;
          end else begin
            status_d = ST_FIRED;
            fid_d    = pend_id_q;
            ftime_d  = pend_time_q;
          end
        end else begin
          if (rd_mark) begin
            sub_d      = rd_due;
            tgt_d      = tgt_q - rd_due;
            cur_d      = '0;
            reb_d      = 1'b1;
            ins_due_d  = REBASE_DELAY;
            ins_id_d   = '0;
            ins_mark_d = 1'b1;
            ins_adv_d  = 1'b1;
          end else begin
            if (n_q != '0) begin
              stb_d    = 1'b1;
              status_d = ST_FIRED;
              fid_d    = pend_id_q;
              ftime_d  = pend_time_q;
              last_d   = 1'b0;
            end
            pend_id_d   = rd_id;
            pend_time_d = rd_due;
            n_d         = n_q + 1'b1;
            cur_d       = rd_due;
            sub_d       = '0;
            reb_d       = 1'b0;
          end
          if (cnt_q == CW'(1)) begin
            cnt_d = '0;
            if (rd_mark) begin
              idx_d   = '0;
              state_d = S_INS_PUT;
            end else begin
              raddr   = '0;
              state_d = S_ADV_CHK;
            end
          end else begin
            raddr   = AW'(1);
            idx_d   = AW'(1);
            state_d = S_POP;
          end
        end
      end

      S_POP: begin
        // Shift entries down by one, rebasing their due times
        we    = 1'b1;
        waddr = idx_q - 1'b1;
        wdata = {rd_mark, rd_id, rd_due - sub_q};
        if (idx_p1 < cnt_q) begin
          raddr = idx_p1[AW-1:0];
          idx_d = idx_p1[AW-1:0];
        end else begin
          cnt_d = cnt_m1;
          if (reb_q) begin
            idx_d   = cnt_m1[AW-1:0];
            raddr   = cnt_m1[AW-1:0] - 1'b1;
            state_d = S_INS_SCAN;
          end else begin
            raddr   = '0;
            state_d = S_ADV_CHK;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cur_q   <= '0;
      cnt_q   <= CW'(1);
      idx_q   <= '0;
      n_q     <= '0;
      reb_q   <= 1'b0;
      stb_q   <= 1'b0;
      ins_adv_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      reb_q   <= reb_d;
      stb_q   <= stb_d;
      ins_adv_q <= ins_adv_d;
      fwd_q   <= fwd_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    sub_q       <= sub_d;
    ins_due_q   <= ins_due_d;
    ins_id_q    <= ins_id_d;
    ins_mark_q  <= ins_mark_d;
    pend_id_q   <= pend_id_d;
    pend_time_q <= pend_time_d;
    status_q    <= status_d;
    fid_q       <= fid_d;
    ftime_q     <= ftime_d;
    last_q      <= last_d;
    fwd_data_q  <= fwd_data_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = stb_q;
  assign status_o       = status_q;
  assign fired_id_o     = fid_q;
  assign fire_time_o    = ftime_q;
  assign last_o         = last_q;

  `ASSERT_ALWAYS(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q < CW'(QUEUE_DEPTH), "entry count overflow")
  `ASSERT_ALWAYS(a_n_bound, clk_i, rst_ni, n_q <= N_WIDTH'(MAX_OUT), "too many fired results")
  `ASSERT_IMPLY(a_plain_result, clk_i, rst_ni, stb_q && status_q != ST_FIRED,
    last_q && fid_q == '0 && ftime_q == '0, "non-fired result not clean")

endmodule
